/* rtl/tmrm_pkg.sv */
// shared types, sizes, the list length clamp and the move compare function of the tabu move ring match unit
// no dependencies; tmrm_scan and the top level import it
package tmrm_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LEN_W  = $clog2(DEPTH + 1);
	localparam int CFG_W  = 11;
	localparam int CITY_W = 10;
	localparam int EXT_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;

	localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(1024);

	typedef logic [CITY_W-1:0] city_t;

	typedef struct packed {
		city_t b_next;
		city_t b;
		city_t a_next;
		city_t a;
	} move_t;

	localparam int MOVE_W = $bits(move_t);

	typedef enum logic [1:0] {
		ACT_CHECK = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic {
		SC_IDLE,
		SC_SCAN
	} scan_state_t;

	typedef struct packed {
		logic  start;
		move_t move;
	} scan_req_t;

	typedef struct packed {
		logic idle;
		logic done;
		logic hit;
	} scan_rsp_t;

	function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] cfg);
		logic [EXT_W-1:0] v;
		v = EXT_W'(cfg);
		if (v == '0)
			v = EXT_W'(1);
		if (v > EXT_W'(DEPTH))
			v = EXT_W'(DEPTH);
		return LEN_W'(v);
	endfunction

	function automatic logic move_hit(input move_t e, input move_t m);
		return (e.a == m.a      && e.a_next == m.b      && e.b == m.a_next && e.b_next == m.b_next)
		    || (e.a == m.a_next && e.a_next == m.b_next && e.b == m.a      && e.b_next == m.b)
		    || (e.a == m.b      && e.a_next == m.a      && e.b == m.b_next && e.b_next == m.a_next)
		    || (e.a == m.b_next && e.a_next == m.a_next && e.b == m.b      && e.b_next == m.a);
	endfunction

endpackage

/* rtl/tmrm_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module tmrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* rtl/tmrm_scan.sv */
// check sequencer: reads one stored move per cycle and compares the four reorderings
// depends on tmrm_pkg; drives the read port of tmrm_ram
module tmrm_scan (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tmrm_pkg::scan_req_t      req,
	input  logic [tmrm_pkg::LEN_W-1:0]  len,
	input  logic [tmrm_pkg::LEN_W-1:0]  fill,
	output logic                     rd_en,
	output logic [tmrm_pkg::ADDR_W-1:0] rd_addr,
	input  tmrm_pkg::move_t          rd_data,
	output tmrm_pkg::scan_rsp_t      rsp
);

	import tmrm_pkg::*;

	scan_state_t       state_q, state_d;
	logic [LEN_W-1:0]  cnt_q;
	logic              valid_s1;
	logic [ADDR_W-1:0] idx_s1;
	move_t             mv_q;
	move_t             entry;
	logic              issue;
	logic              done;
	logic              match;

	// entries at or above the fill count were never written since clear
	assign entry = (LEN_W'(idx_s1) < fill) ? rd_data : '0;

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		done    = 1'b0;
		match   = valid_s1 && move_hit(entry, mv_q);
		unique case (state_q)
			SC_IDLE: begin
				if (req.start)
					state_d = SC_SCAN;
			end
			SC_SCAN: begin
				if (match || (cnt_q == len && !valid_s1)) begin
					done    = 1'b1;
					state_d = SC_IDLE;
				end else if (cnt_q < len) begin
					issue = 1'b1;
				end
			end
			default: state_d = SC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SC_IDLE;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (state_q == SC_IDLE && req.start)
				cnt_q <= '0;
			else if (issue)
				cnt_q <= cnt_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SC_IDLE && req.start)
			mv_q <= req.move;
		idx_s1 <= cnt_q[ADDR_W-1:0];
	end

	assign rd_en    = issue;
	assign rd_addr  = cnt_q[ADDR_W-1:0];
	assign rsp.idle = (state_q == SC_IDLE);
	assign rsp.done = done;
	assign rsp.hit  = match;

	a_done_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> state_q == SC_IDLE && !valid_s1)
		else $error("scan did not stop after its response");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> cnt_q < len)
		else $error("scan read beyond the list length");

endmodule

/* rtl/tabu_move_ring_match_unit.sv */
// top level of the tabu move ring match unit: stream ports, write pointer, fill count
// depends on tmrm_pkg, tmrm_ram and tmrm_scan
//
// usage
//   s_* carries one move per beat: s_tuser is the action (check, add, clear),
//   s_tdata the four cities. m_* returns one beat per input beat, bit 0 of
//   m_tdata is is_tabu (only a check can set it).
//   cfg_wen/cfg_wdata write list_length; write it only while the unit is idle.
//   add, clear and unused actions give a registered result that
//   shows on m_* the next cycle.
//   a check reads the move store through its single read port, one entry per
//   cycle, and ends early on a hit.
//   one move is worked on at a time; s_tready is low during a check and while
//   a result waits in the output register and m_tready is low.
//   reset clears the pointer, the fill count and list_length (to 1024); a clear
//   does the same for pointer and fill count. entries at or above the fill count
//   read as zero, so the store needs no clearing pass.
module tabu_move_ring_match_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [39:0]               s_tdata,  // city_a, city_a_next, city_b, city_b_next
	input  logic [1:0]                s_tuser,  // action
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,  // is_tabu, zero fill
	input  logic                      cfg_wen,
	input  logic [tmrm_pkg::CFG_W-1:0] cfg_wdata
);

	import tmrm_pkg::*;

	logic [CFG_W-1:0]  len_cfg_q;
	logic [LEN_W-1:0]  len;
	logic [ADDR_W-1:0] ptr_q;
	logic [LEN_W-1:0]  fill_q;
	logic [ADDR_W-1:0] ptr_eff;
	logic [LEN_W-1:0]  ptr_inc;
	logic              out_valid_q;
	logic              out_q;
	logic              acc;
	action_t           action;
	move_t             move;
	logic              wr_en;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	move_t             rd_data;
	scan_req_t         req;
	scan_rsp_t         rsp;

	assign len     = eff_len(len_cfg_q);
	assign action  = action_t'(s_tuser);
	assign move    = move_t'(s_tdata);
	assign s_tready = rsp.idle && (!out_valid_q || m_tready);
	assign acc     = s_tvalid && s_tready;
	assign wr_en   = acc && action == ACT_ADD;

	assign ptr_eff = (LEN_W'(ptr_q) >= len) ? '0 : ptr_q;
	assign ptr_inc = LEN_W'(ptr_eff) + LEN_W'(1);

	assign req.start = acc && action == ACT_CHECK;
	assign req.move  = move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q   <= LEN_RESET;
			ptr_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen)
				len_cfg_q <= cfg_wdata;
			if (acc) begin
				case (action)
					ACT_ADD: begin
						ptr_q <= (ptr_inc >= len) ? '0 : ptr_inc[ADDR_W-1:0];
						if (ptr_inc > fill_q)
							fill_q <= ptr_inc;
					end
					ACT_CLEAR: begin
						ptr_q  <= '0;
						fill_q <= '0;
					end
					default: ;
				endcase
			end
			if ((acc && action != ACT_CHECK) || rsp.done)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.done)
			out_q <= rsp.hit;
		else if (acc && action != ACT_CHECK)
			out_q <= 1'b0;
	end

	tmrm_ram #(
		.WIDTH (MOVE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ptr_eff),
		.wdata (move),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	tmrm_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.len     (len),
		.fill    (fill_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rsp     (rsp)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_q};

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> !out_valid_q)
		else $error("check result with the output register still full");

	a_ptr_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(ptr_q) <= fill_q && fill_q <= LEN_W'(DEPTH))
		else $error("write pointer or fill count out of range");

	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc && action != ACT_CHECK |=> m_tvalid && m_tdata == 8'd0)
		else $error("add or clear did not return a zero result");

endmodule
